// File: src/rvg_pkg.sv
package rvg_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_HEIGHT_AXIS      = 3'd0;
    localparam logic [2:0] CFG_MIRROR_COPIES    = 3'd1;
    localparam logic [2:0] CFG_HUE_SPREAD       = 3'd2;
    localparam logic [2:0] CFG_HUE_FLOW         = 3'd3;
    localparam logic [2:0] CFG_BRIGHTNESS_SCALE = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Height axis codes.
    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_ALL = 2'd3;

    localparam int COLOR_MAX_DEFAULT   = 255;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [16:0] PHASE_STEP = 17'd4;
    localparam logic [16:0] PHASE_WRAP = 17'd100000;

    // floor(2^32 / 125), used to divide the hue drift product by 125.
    localparam logic [25:0] RECIP_125 = 26'd34359738;

    typedef struct packed {
        logic [1:0]  height_axis;
        logic        mirror_two;
        logic [8:0]  hue_spread;
        logic [10:0] hue_flow;
        logic [8:0]  brightness_scale;
    } cfg_t;

    // One classified point waiting for its voxels to be sent.
    typedef struct packed {
        logic [1:0] px;
        logic [1:0] py;
        logic [2:0] h;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } desc_t;

    // Ten times the distance of a quadrant point from the cube centre.
    function automatic logic [5:0] centre_dist(input logic [1:0] x, input logic [1:0] y);
        logic [5:0] d;
        unique case ({x, y})
            4'h0: d = 6'd49;
            4'h1: d = 6'd43;
            4'h2: d = 6'd38;
            4'h3: d = 6'd35;
            4'h4: d = 6'd43;
            4'h5: d = 6'd35;
            4'h6: d = 6'd29;
            4'h7: d = 6'd25;
            4'h8: d = 6'd38;
            4'h9: d = 6'd29;
            4'hA: d = 6'd21;
            4'hB: d = 6'd16;
            4'hC: d = 6'd35;
            4'hD: d = 6'd25;
            4'hE: d = 6'd16;
            default: d = 6'd7;
        endcase
        return d;
    endfunction

    // Surface height 0..7 for one step of the 128-step sine wave.
    function automatic logic [2:0] height_of_step(input logic [7:0] k);
        logic [5:0] j;
        logic [5:0] m;
        logic [2:0] lvl;
        logic [6:0] k7;
        j = k[5:0];
        m = (j <= 6'd32) ? j : 6'(7'd64 - {1'b0, j});
        if (m < 6'd6) begin
            lvl = 3'd0;
        end
        else if (m < 6'd12) begin
            lvl = 3'd1;
        end
        else if (m < 6'd20) begin
            lvl = 3'd2;
        end
        else begin
            lvl = 3'd3;
        end
        k7 = k[6:0];
        return (k7 <= 7'd64) ? 3'd4 + lvl : 3'd3 - lvl;
    endfunction

endpackage

// File: src/rvg_queue.sv
module rvg_queue #(
    parameter int DEPTH = rvg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rvg_pkg::desc_t push_data,
    output logic          full,
    input  logic          pop,
    output rvg_pkg::desc_t head,
    output logic          empty
);
    import rvg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/rvg_front.sv
module rvg_front #(
    parameter int COLOR_MAX = rvg_pkg::COLOR_MAX_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rvg_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     point_x,
    input  logic [1:0]     point_y,
    input  logic           frame_end,
    output logic           push,
    output rvg_pkg::desc_t push_data,
    input  logic           full
);
    import rvg_pkg::*;

    localparam int CW        = $clog2(COLOR_MAX + 1);
    localparam int MW        = 26 + CW;
    localparam int RW        = MW + 1 - 24;
    localparam int LEVEL_MAX = (COLOR_MAX > 255) ? 255 : COLOR_MAX;

    localparam logic [2:0] STEP_LAST = 3'd5;

    logic        busy_reg, busy_next;
    logic [2:0]  step_reg, step_next;
    logic [16:0] phase_reg, phase_next;
    logic        accept;

    logic [1:0]  px_reg, py_reg;
    logic [2:0]  h_reg;
    logic [27:0] prod_reg;
    logic [24:0] quot_reg;
    logic [15:0] hs_reg;
    logic [15:0] hue_reg;
    logic [16:0] comp_reg [3];
    logic [25:0] mul1_reg [3];
    logic [MW-1:0] mul2_reg [3];

    logic [57:0] recip_prod;
    logic [31:0] dividend;
    logic [31:0] remainder;
    logic [15:0] drift;
    logic [18:0] h6;
    logic [15:0] frac;
    logic [16:0] comp_next [3];
    logic [7:0]  level [3];
    logic [MW:0] rounded [3];
    logic [16:0] phase_sum;

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;
    assign push     = busy_reg && (step_reg == STEP_LAST) && !full;

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        phase_sum  = phase_reg + PHASE_STEP;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
            if (frame_end)
            begin
                phase_next = (phase_sum >= PHASE_WRAP) ? phase_sum - PHASE_WRAP : phase_sum;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg != STEP_LAST)
            begin
                step_next = step_reg + 1'b1;
            end
            else if (!full)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    // Drift divide by 125: reciprocal estimate, then one correction step.
    always_comb
    begin
        dividend   = {prod_reg, 4'b0000};
        recip_prod = 58'(dividend) * 58'(RECIP_125);
        remainder  = dividend - 32'(quot_reg) * 32'd125;
        drift      = quot_reg[15:0] + ((remainder >= 32'd125) ? 16'd1 : 16'd0);
        h6         = 19'(hue_reg) * 19'd6;
        frac       = h6[15:0];
    end

    // Six-sector hue wheel, components in Q1.16.
    always_comb
    begin
        unique case (h6[18:16])
            3'd0:
            begin
                comp_next[0] = 17'h10000;
                comp_next[1] = {1'b0, frac};
                comp_next[2] = '0;
            end
            3'd1:
            begin
                comp_next[0] = 17'h10000 - {1'b0, frac};
                comp_next[1] = 17'h10000;
                comp_next[2] = '0;
            end
            3'd2:
            begin
                comp_next[0] = '0;
                comp_next[1] = 17'h10000;
                comp_next[2] = {1'b0, frac};
            end
            3'd3:
            begin
                comp_next[0] = '0;
                comp_next[1] = 17'h10000 - {1'b0, frac};
                comp_next[2] = 17'h10000;
            end
            3'd4:
            begin
                comp_next[0] = {1'b0, frac};
                comp_next[1] = '0;
                comp_next[2] = 17'h10000;
            end
            default:
            begin
                comp_next[0] = 17'h10000;
                comp_next[1] = '0;
                comp_next[2] = 17'h10000 - {1'b0, frac};
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rounded[i] = {1'b0, mul2_reg[i]} + (MW + 1)'(1 << 23);
            if (rounded[i][MW:24] > RW'(LEVEL_MAX))
            begin
                level[i] = 8'(LEVEL_MAX);
            end
            else
            begin
                level[i] = 8'(rounded[i][MW:24]);
            end
        end
    end

    assign push_data.px    = px_reg;
    assign push_data.py    = py_reg;
    assign push_data.h     = h_reg;
    assign push_data.red   = level[0];
    assign push_data.green = level[1];
    assign push_data.blue  = level[2];

    // The datapath settles stage by stage while the step counter runs.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            h_reg    <= height_of_step(8'(centre_dist(point_x, point_y))
                                       + 8'(phase_reg[6:0]));
            prod_reg <= 28'(phase_reg) * 28'(cfg.hue_flow);
        end
        quot_reg <= recip_prod[56:32];
        hs_reg   <= 16'(16'(h_reg) * 16'(cfg.hue_spread) << 5);
        hue_reg  <= hs_reg + drift;
        for (int i = 0; i < 3; i++)
        begin
            comp_reg[i] <= comp_next[i];
            mul1_reg[i] <= 26'(comp_reg[i]) * 26'(cfg.brightness_scale);
            mul2_reg[i] <= MW'(mul1_reg[i]) * MW'(COLOR_MAX);
        end
    end

endmodule

// File: src/rvg_back.sv
module rvg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rvg_pkg::cfg_t  cfg,
    input  rvg_pkg::desc_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     voxel_x,
    output logic [2:0]     voxel_y,
    output logic [2:0]     voxel_z,
    output logic [7:0]     red_level,
    output logic [7:0]     green_level,
    output logic [7:0]     blue_level,
    output logic           last_voxel
);
    import rvg_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] pass_reg, pass_next;
    logic [1:0] quad_reg, quad_next;
    logic       copy_reg, copy_next;

    logic [2:0] vx_reg, vy_reg, vz_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       last_reg;

    logic       load, emit;
    logic       copy_done, quad_done, pass_done;
    logic [1:0] axis;
    logic [2:0] hh, u, v;
    logic [2:0] vx, vy, vz;

    assign load = !out_valid_reg || !out_stall;
    assign emit = load && !empty;

    assign copy_done = !cfg.mirror_two || copy_reg;
    assign quad_done = (quad_reg == 2'd3);
    assign pass_done = (cfg.height_axis == AXIS_ALL) ? (pass_reg == 2'd2) : 1'b1;
    assign pop       = emit && copy_done && quad_done && pass_done;

    always_comb
    begin
        axis = (cfg.height_axis == AXIS_ALL) ? pass_reg : cfg.height_axis;
        hh   = copy_reg ? 3'd7 - head.h : head.h;
        u    = quad_reg[0] ? 3'd7 - {1'b0, head.px} : {1'b0, head.px};
        v    = quad_reg[1] ? 3'd7 - {1'b0, head.py} : {1'b0, head.py};
        unique case (axis)
            AXIS_X:
            begin
                vx = hh;
                vy = u;
                vz = v;
            end
            AXIS_Y:
            begin
                vx = u;
                vy = hh;
                vz = v;
            end
            default:
            begin
                vx = u;
                vy = v;
                vz = hh;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pass_next      = pass_reg;
        quad_next      = quad_reg;
        copy_next      = copy_reg;
        if (load)
        begin
            out_valid_next = !empty;
        end
        if (emit)
        begin
            if (!copy_done)
            begin
                copy_next = 1'b1;
            end
            else
            begin
                copy_next = 1'b0;
                if (!quad_done)
                begin
                    quad_next = quad_reg + 1'b1;
                end
                else
                begin
                    quad_next = '0;
                    pass_next = pass_done ? 2'd0 : pass_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pass_reg      <= '0;
            quad_reg      <= '0;
            copy_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
            quad_reg      <= quad_next;
            copy_reg      <= copy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vx_reg    <= vx;
            vy_reg    <= vy;
            vz_reg    <= vz;
            red_reg   <= head.red;
            green_reg <= head.green;
            blue_reg  <= head.blue;
            last_reg  <= copy_done && quad_done && pass_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign voxel_x     = vx_reg;
    assign voxel_y     = vy_reg;
    assign voxel_z     = vz_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;
    assign last_voxel  = last_reg;

endmodule

// File: src/ripple_voxel_generator.sv
// A point's first voxel reaches the output once the front has run its six steps through the
// colour datapath and the point has passed the queue and the back's output register.
// The front takes a new point only once done with the last; the back sends one voxel per
// cycle unless the output stalls or the queue is empty; a point gives 4, 8, 12 or 24 voxels.
// Reset: wave phase cleared, registers at their defaults, queue and output empty.
module ripple_voxel_generator #(
    parameter int COLOR_MAX   = rvg_pkg::COLOR_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = rvg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rvg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rvg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      point_x,
    input  logic [1:0]                      point_y,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      voxel_x,
    output logic [2:0]                      voxel_y,
    output logic [2:0]                      voxel_z,
    output logic [7:0]                      red_level,
    output logic [7:0]                      green_level,
    output logic [7:0]                      blue_level,
    output logic                            last_voxel
);
    import rvg_pkg::*;

    // Configuration registers. Each value is clamped to its legal range as it
    // is written, so the datapath never sees an out-of-range setting.
    cfg_t cfg_reg, cfg_next;

    // Handshake between the front (point classification and colour) and the
    // back (voxel expansion), through a short queue of finished points.
    logic  push, full, pop, empty;
    desc_t push_data, head;

    logic [8:0]  spread_in;
    logic [10:0] flow_in;
    logic [8:0]  bright_in;

    // Takes every write; the user must write only while the block is idle, unenforced.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next  = cfg_reg;
        spread_in = cfg_data[8:0];
        flow_in   = cfg_data[10:0];
        bright_in = cfg_data[8:0];
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEIGHT_AXIS:
                begin
                    cfg_next.height_axis = cfg_data[1:0];
                end
                CFG_MIRROR_COPIES:
                begin
                    // A code of 0 or 1 means one surface, 2 or 3 adds the reflection.
                    cfg_next.mirror_two = cfg_data[1];
                end
                CFG_HUE_SPREAD:
                begin
                    cfg_next.hue_spread = (spread_in > 9'd256) ? 9'd256 : spread_in;
                end
                CFG_HUE_FLOW:
                begin
                    cfg_next.hue_flow = (flow_in > 11'd1024) ? 11'd1024 : flow_in;
                end
                CFG_BRIGHTNESS_SCALE:
                begin
                    if (bright_in < 9'd38)
                    begin
                        cfg_next.brightness_scale = 9'd38;
                    end
                    else if (bright_in > 9'd256)
                    begin
                        cfg_next.brightness_scale = 9'd256;
                    end
                    else
                    begin
                        cfg_next.brightness_scale = bright_in;
                    end
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height_axis      <= AXIS_Z;
            cfg_reg.mirror_two       <= 1'b0;
            cfg_reg.hue_spread       <= 9'd90;
            cfg_reg.hue_flow         <= 11'd256;
            cfg_reg.brightness_scale <= 9'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front holds the wave phase, looks up the height of the point and
    // works out its colour; it stalls its input while a point is in flight.
    rvg_front #(
        .COLOR_MAX (COLOR_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .frame_end (frame_end),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // The queue lets the front start on the next point while the back is
    // still sending the mirrored voxels of the earlier one.
    rvg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // The back walks axes, quadrants and copies into an output register, one voxel
    // per cycle unless stalled or out of points, and marks the final voxel of each point.
    rvg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .last_voxel  (last_voxel)
    );

endmodule

// File: tb/sv/ripple_voxel_generator_tb.sv
// Self-checking bench for the ripple voxel generator.
//
// Quadrant points are queued by the sequencing block below and presented by a
// driver at the falling clock edge. A monitor samples both handshakes at the
// rising edge. Each accepted item is expanded at once into the voxels that it
// must cause, and every voxel that leaves the block is compared with the oldest
// of those.
module ripple_voxel_generator_tb;

    import rvg_pkg::*;

    localparam int COLOR_MAX    = COLOR_MAX_DEFAULT;
    localparam int REPORT_LIMIT = 10;
    // The limit lies far above the longest stretch with no handshake at all
    // in a correct run, even under heavy idling.
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [1:0] x;
        logic [1:0] y;
        logic       fend;
    } point_t;

    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } voxel_t;

    // Block ports. Every input starts at a known value.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             point_x = '0;
    logic [1:0]             point_y = '0;
    logic                   frame_end = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [2:0]             voxel_x;
    logic [2:0]             voxel_y;
    logic [2:0]             voxel_z;
    logic [7:0]             red_level;
    logic [7:0]             green_level;
    logic [7:0]             blue_level;
    logic                   last_voxel;

    // Mirror of the block's registers and of its wave phase, as the bench
    // believes them to be after every write and every accepted item.
    logic [1:0]  axis_sel = AXIS_Z;
    logic [1:0]  copies = 2'd1;
    logic [8:0]  spread = 9'd90;
    logic [10:0] flow = 11'd256;
    logic [8:0]  bright = 9'd256;
    logic [16:0] phase = '0;

    point_t points_pending[$];
    voxel_t voxels_due[$];
    point_t next_point;
    bit     point_taken = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned fault_count = 0;
    int unsigned points_sent = 0;
    int unsigned voxels_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned phase_wraps = 0;
    int unsigned phases_run = 0;
    int unsigned quiet_cycles = 0;

    ripple_voxel_generator #(
        .COLOR_MAX(COLOR_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .point_x(point_x),
        .point_y(point_y),
        .frame_end(frame_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .voxel_x(voxel_x),
        .voxel_y(voxel_y),
        .voxel_z(voxel_z),
        .red_level(red_level),
        .green_level(green_level),
        .blue_level(blue_level),
        .last_voxel(last_voxel)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Ten times the distance of a quadrant point from the cube centre. Each
    // row holds one x, with y = 0 in the lowest six bits.
    function automatic logic [5:0] dist_tenths(input logic [1:0] x, input logic [1:0] y);
        logic [23:0] row;
        case (x)
            2'd0:    row = {6'd35, 6'd38, 6'd43, 6'd49};
            2'd1:    row = {6'd25, 6'd29, 6'd35, 6'd43};
            2'd2:    row = {6'd16, 6'd21, 6'd29, 6'd38};
            default: row = {6'd7, 6'd16, 6'd25, 6'd35};
        endcase
        return row[y * 6 +: 6];
    endfunction

    // Height of the wave surface at a point. The step on the 128-step sine is
    // folded into a quarter wave, and the quarter is cut into four bands that
    // climb from the centre line (4) in the upper half and fall from 3 in the
    // lower half. The two zero crossings land on the centre line exactly.
    function automatic logic [2:0] surface_height(input logic [1:0] x, input logic [1:0] y,
                                                  input logic [16:0] ph);
        logic [6:0] k;
        logic [5:0] m;
        logic [2:0] band;
        k = 7'(dist_tenths(x, y) + ph[6:0]);
        m = k[5] ? 6'(7'd64 - {1'b0, k[5:0]}) : k[5:0];
        if (m < 6'd6)
        begin
            band = 3'd0;
        end
        else if (m < 6'd12)
        begin
            band = 3'd1;
        end
        else if (m < 6'd20)
        begin
            band = 3'd2;
        end
        else
        begin
            band = 3'd3;
        end
        return (k <= 7'd64) ? 3'd4 + band : 3'd3 - band;
    endfunction

    // A Q1.16 colour component scaled by the brightness and the colour
    // maximum, rounded half up and saturated to the 8-bit level.
    function automatic logic [7:0] scale_level(input logic [16:0] comp);
        logic [63:0] lv;
        lv = (64'(comp) * 64'(bright) * 64'(COLOR_MAX) + 64'd8388608) >> 24;
        if (lv > 64'(COLOR_MAX))
        begin
            lv = 64'(COLOR_MAX);
        end
        if (lv > 64'd255)
        begin
            lv = 64'd255;
        end
        return lv[7:0];
    endfunction

    // Works out every voxel that one accepted item must cause, in the order in
    // which the block sends them, and then advances the wave phase if the item
    // closes a frame.
    task automatic expand_point(input point_t p);
        logic [2:0]  h;
        logic [2:0]  hh;
        logic [2:0]  u;
        logic [2:0]  w;
        logic [63:0] drift;
        logic [15:0] hue;
        logic [18:0] h6;
        logic [16:0] f;
        logic [16:0] cr;
        logic [16:0] cg;
        logic [16:0] cb;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        voxel_t      v;
        int          a_lo;
        int          a_hi;
        int          total;
        int          k;
        h = surface_height(p.x, p.y, phase);
        drift = (64'(phase) * 64'(flow) * 64'd16) / 64'd125;
        hue = 16'(64'(h) * 64'(spread) * 64'd32 + drift);
        h6 = 19'(hue) * 19'd6;
        f = {1'b0, h6[15:0]};
        // Six sectors of the hue wheel: one component full, one empty and one
        // ramping with the fraction of the sector.
        case (h6[18:16])
            3'd0:
            begin
                cr = 17'h10000; cg = f; cb = '0;
            end
            3'd1:
            begin
                cr = 17'h10000 - f; cg = 17'h10000; cb = '0;
            end
            3'd2:
            begin
                cr = '0; cg = 17'h10000; cb = f;
            end
            3'd3:
            begin
                cr = '0; cg = 17'h10000 - f; cb = 17'h10000;
            end
            3'd4:
            begin
                cr = f; cg = '0; cb = 17'h10000;
            end
            default:
            begin
                cr = 17'h10000; cg = '0; cb = 17'h10000 - f;
            end
        endcase
        r = scale_level(cr);
        g = scale_level(cg);
        b = scale_level(cb);

        if (axis_sel == AXIS_ALL)
        begin
            a_lo = int'(AXIS_X);
            a_hi = int'(AXIS_Z);
        end
        else
        begin
            a_lo = int'(axis_sel);
            a_hi = int'(axis_sel);
        end
        total = (a_hi - a_lo + 1) * 4 * int'(copies);
        k = 0;
        for (int a = a_lo; a <= a_hi; a++)
        begin
            // Quadrants in order: as given, x flipped, y flipped, both flipped.
            for (int q = 0; q < 4; q++)
            begin
                u = q[0] ? 3'd7 - {1'b0, p.x} : {1'b0, p.x};
                w = q[1] ? 3'd7 - {1'b0, p.y} : {1'b0, p.y};
                for (int c = 0; c < int'(copies); c++)
                begin
                    hh = (c == 0) ? h : 3'd7 - h;
                    case (2'(a))
                        AXIS_X:
                        begin
                            v.x = hh; v.y = u; v.z = w;
                        end
                        AXIS_Y:
                        begin
                            v.x = u; v.y = hh; v.z = w;
                        end
                        default:
                        begin
                            v.x = u; v.y = w; v.z = hh;
                        end
                    endcase
                    v.r = r;
                    v.g = g;
                    v.b = b;
                    v.last = (k == total - 1);
                    voxels_due.push_back(v);
                    k++;
                end
            end
        end

        if (p.fend)
        begin
            phase = phase + PHASE_STEP;
            if (phase >= PHASE_WRAP)
            begin
                phase = phase - PHASE_WRAP;
                phase_wraps++;
            end
        end
    endtask

    // Compares one voxel leaving the block with the oldest one still due.
    task automatic check_voxel();
        voxel_t got;
        voxel_t want;
        got = {voxel_x, voxel_y, voxel_z, red_level, green_level, blue_level, last_voxel};
        if (voxels_due.size() == 0)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
            begin
                $display("Unexpected voxel (%0d,%0d,%0d) rgb (%0d,%0d,%0d) last %0b",
                         got.x, got.y, got.z, got.r, got.g, got.b, got.last);
            end
        end
        else
        begin
            want = voxels_due.pop_front();
            voxels_checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                || got.r !== want.r || got.g !== want.g || got.b !== want.b
                || got.last !== want.last)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                begin
                    $display("Voxel mismatch: expected (%0d,%0d,%0d) rgb (%0d,%0d,%0d) last %0b",
                             want.x, want.y, want.z, want.r, want.g, want.b, want.last);
                    $display("                got      (%0d,%0d,%0d) rgb (%0d,%0d,%0d) last %0b",
                             got.x, got.y, got.z, got.r, got.g, got.b, got.last);
                end
            end
        end
    endtask

    // Monitor: both handshakes are sampled at the rising edge, where every
    // value still holds what it had through the cycle just ended.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            point_taken = in_valid && !in_stall;
            if (point_taken)
            begin
                expand_point('{x: point_x, y: point_y, fend: frame_end});
                points_sent++;
            end
            if (out_valid && !out_stall)
            begin
                check_voxel();
            end
        end
    end

    // Driver: a new item is presented once the previous one has been taken,
    // unless the sender chooses to idle this cycle. A stalled item stays put.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || point_taken))
        begin
            if (points_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_point = points_pending.pop_front();
                point_x <= next_point.x;
                point_y <= next_point.y;
                frame_end <= next_point.fend;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random, whether or not a voxel is on offer.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d voxels still due",
                     QUIET_LIMIT, voxels_due.size());
            $display("ripple_voxel_generator_tb: done, errors");
            $finish;
        end
    end

    // Writes one register and updates the bench's copy with the same clamping
    // that the block applies. The write strobe is left high for a following
    // write; lower_cfg_strobe drops it at the end of a sequence.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_HEIGHT_AXIS:
            begin
                axis_sel = val[1:0];
            end
            CFG_MIRROR_COPIES:
            begin
                copies = (val[1:0] == 2'd0) ? 2'd1 : (val[1:0] == 2'd3) ? 2'd2 : val[1:0];
            end
            CFG_HUE_SPREAD:
            begin
                spread = (val[8:0] > 9'd256) ? 9'd256 : val[8:0];
            end
            CFG_HUE_FLOW:
            begin
                flow = (val > 11'd1024) ? 11'd1024 : val;
            end
            CFG_BRIGHTNESS_SCALE:
            begin
                bright = (val[8:0] < 9'd38) ? 9'd38 : (val[8:0] > 9'd256) ? 9'd256 : val[8:0];
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic lower_cfg_strobe();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all five registers with raw values; out-of-range values are
    // deliberate, to see them clamped.
    task automatic configure(input logic [10:0] ax, input logic [10:0] mc, input logic [10:0] hs,
                             input logic [10:0] hf, input logic [10:0] bs);
        write_reg(CFG_HEIGHT_AXIS, ax);
        write_reg(CFG_MIRROR_COPIES, mc);
        write_reg(CFG_HUE_SPREAD, hs);
        write_reg(CFG_HUE_FLOW, hf);
        write_reg(CFG_BRIGHTNESS_SCALE, bs);
        lower_cfg_strobe();
    endtask

    // Idling modes: none, a sender that mostly idles, a receiver that mostly
    // stalls, and both at a moderate rate.
    task automatic set_idling(input int mode);
        case (mode)
            1:
            begin
                send_idle_pct = 85; stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0; stall_pct = 85;
            end
            3:
            begin
                send_idle_pct = 34; stall_pct = 34;
            end
            default:
            begin
                send_idle_pct = 0; stall_pct = 0;
            end
        endcase
    endtask

    task automatic queue_point(input int x, input int y, input bit fend);
        points_pending.push_back('{x: 2'(x), y: 2'(y), fend: fend});
    endtask

    // Random points with roughly every third one closing a frame, so that the
    // wave phase keeps moving and the sine and hue wheel are swept through.
    task automatic queue_random_points(input int n);
        for (int i = 0; i < n; i++)
        begin
            queue_point($urandom_range(3), $urandom_range(3), $urandom_range(99) < 30);
        end
    endtask

    // Waits until every queued item has been taken and every voxel it caused
    // has arrived. Each item causes at least four voxels, so the block is idle
    // by then and registers may be written.
    task automatic drain();
        do
            @(posedge clk);
        while (points_pending.size() != 0 || in_valid || voxels_due.size() != 0);
        phases_run++;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the registers at their reset values: every
        // quadrant point once, then a mix of corner and inner points, most of which
        // close frames, so that the wave phase moves under known conditions.
        set_idling(0);
        for (int x = 0; x < 4; x++)
        begin
            for (int y = 0; y < 4; y++)
            begin
                queue_point(x, y, 1'b0);
            end
        end
        queue_point(3, 3, 1'b1);
        queue_point(0, 0, 1'b1);
        queue_point(3, 0, 1'b1);
        queue_point(0, 3, 1'b1);
        queue_point(2, 1, 1'b1);
        queue_point(1, 2, 1'b0);
        queue_point(3, 3, 1'b1);
        queue_point(0, 0, 1'b0);
        drain();

        // Random phases. The first four hold mostly register extremes, including
        // raw values beyond the legal ranges; the rest are fully random. Each
        // phase runs under one of the four idling modes in turn.
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: configure(11'(AXIS_X), 11'd2, 11'd256, 11'd1024, 11'd256);
                1: configure(11'(AXIS_Y), 11'd0, 11'd0, 11'd0, 11'd38);
                2: configure(11'(AXIS_ALL), 11'd3, 11'd511, 11'd2047, 11'd0);
                3: configure(11'(AXIS_ALL), 11'd1, 11'($urandom_range(2047)),
                             11'($urandom_range(2047)), 11'd511);
                default: configure(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                                   11'($urandom_range(2047)), 11'($urandom_range(2047)),
                                   11'($urandom_range(2047)));
            endcase
            set_idling(p % 4);
            queue_random_points(33);
            drain();
        end

        // Let any voxel the block should not have sent show itself.
        set_idling(0);
        repeat (30) @(posedge clk);
        fault_count += voxels_due.size();

        $display("Run covered %0d points over %0d phases, %0d voxels checked, %0d register writes.",
                 points_sent, phases_run, voxels_checked, reg_writes);
        $display("Wave phase wrapped %0d time(s); %0d fault(s) found.", phase_wraps, fault_count);
        if (fault_count == 0)
        begin
            $display("ripple_voxel_generator_tb: done, clean");
        end
        else
        begin
            $display("ripple_voxel_generator_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: ripple_voxel_generator.f
src/rvg_pkg.sv
src/rvg_queue.sv
src/rvg_front.sv
src/rvg_back.sv
src/ripple_voxel_generator.sv
tb/sv/ripple_voxel_generator_tb.sv
